/* hdl/sorted_priority_queue_with_aging_top_defines.svh */
// Assertion macros shared by the sorted priority queue with aging.
`ifndef SORTED_PRIORITY_QUEUE_WITH_AGING_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_WITH_AGING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define SPQA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SPQA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQA_ASSERT(lbl, expr, msg)
`define SPQA_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPQA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/spqa_pkg.sv */
// Operation codes, status codes and cell control types of the aging priority queue.
`timescale 1ns / 1ps
package spqa_pkg;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_FRONT  = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_PURGE  = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [7:0] PRIO_MIN          = 8'sh80;
  localparam logic signed [7:0] FRONT_BASE_RESET  = 8'sd5;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT,
    CMD_TICK,
    CMD_PURGE
  } spqa_cmd_e;

  typedef struct packed {
    spqa_cmd_e         cmd;
    logic signed [7:0] prio;
    logic [7:0]        pat;
  } spqa_ctrl_t;

endpackage

/* hdl/spqa_cell.sv */
// One storage cell of the sorted queue chain, trading entries with its neighbors.
`timescale 1ns / 1ps
module spqa_cell
  import spqa_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  spqa_ctrl_t               ctrl_i,
  input  logic [PAYLOAD_WIDTH-1:0] ins_payload_i,
  input  logic                     occ_i,
  input  logic                     left_keep_i,
  input  logic                     dead_left_i,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload_i,
  input  logic signed [7:0]        left_prio_i,
  input  logic [7:0]               left_pat_i,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload_i,
  input  logic signed [7:0]        right_prio_i,
  input  logic [7:0]               right_pat_i,
  output logic                     keep_o,
  output logic                     dead_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o,
  output logic signed [7:0]        prio_o,
  output logic [7:0]               pat_o
);

  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;
  logic signed [7:0]        prio_q, prio_d;
  logic [7:0]               pat_q, pat_d;
  logic                     keep;
  logic                     dead;

  always_comb begin
    keep      = occ_i && (prio_q <= ctrl_i.prio);
    dead      = dead_left_i || (occ_i && (pat_q == 8'd0));
    payload_d = payload_q;
    prio_d    = prio_q;
    pat_d     = pat_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (!keep) begin
          if (left_keep_i) begin
            payload_d = ins_payload_i;
            prio_d    = ctrl_i.prio;
            pat_d     = ctrl_i.pat;
          end else begin
            payload_d = left_payload_i;
            prio_d    = left_prio_i;
            pat_d     = left_pat_i;
          end
        end
      end
      CMD_SHIFT: begin
        payload_d = right_payload_i;
        prio_d    = right_prio_i;
        pat_d     = right_pat_i;
      end
      CMD_TICK: begin
        prio_d = (prio_q == PRIO_MIN) ? prio_q : prio_q - 8'sd1;
        pat_d  = (pat_q == 8'd0) ? pat_q : pat_q - 8'd1;
      end
      CMD_PURGE: begin
        if (dead) begin
          payload_d = right_payload_i;
          prio_d    = right_prio_i;
          pat_d     = right_pat_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    prio_q    <= prio_d;
    pat_q     <= pat_d;
  end

  assign keep_o    = keep;
  assign dead_o    = dead;
  assign payload_o = payload_q;
  assign prio_o    = prio_q;
  assign pat_o     = pat_q;

endmodule

/* hdl/sorted_priority_queue_with_aging_top.sv */
// With the result side ready the queue accepts one insert, front insert, remove head, tick or
// unused operation code beat per clock; every cell compares and shifts at once. A purge removes
// expired entries one per cycle through the cell chain: input ready stays low from the purge
// beat until no expired entry is left and the purge result has been loaded. A result that is not
// taken holds the input until it is. Entries are ordered by ascending signed priority, ties in
// arrival order, and each operation returns exactly one result beat.
`timescale 1ns / 1ps
`include "sorted_priority_queue_with_aging_top_defines.svh"
module sorted_priority_queue_with_aging_top
  import spqa_pkg::*;
#(
  parameter int DEPTH         = 8,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [7:0]               cfg_wdata_i,
  input  logic                     op_valid_i,
  output logic                     op_ready_o,
  input  logic [2:0]               operation_i,
  input  logic [PAYLOAD_WIDTH-1:0] in_payload_i,
  input  logic signed [7:0]        in_priority_i,
  input  logic [7:0]               in_patience_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [1:0]               status_o,
  output logic                     out_valid_o,
  output logic [PAYLOAD_WIDTH-1:0] out_payload_o,
  output logic signed [7:0]        out_priority_o,
  output logic [7:0]               out_patience_o,
  output logic [3:0]               occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PURGE = 1'b1;

  logic                     state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic signed [7:0]        base_q;

  logic                     res_valid_q, res_valid_d;
  logic [1:0]               status_q;
  logic                     rvld_q;
  logic [PAYLOAD_WIDTH-1:0] rpay_q;
  logic signed [7:0]        rprio_q;
  logic [7:0]               rpat_q;
  logic [3:0]               occ_q;

  spqa_ctrl_t               ctrl;
  logic                     accept;
  logic                     out_free;
  logic                     load;
  logic [1:0]               status_d;
  logic                     rvld_d;
  logic                     full;
  logic                     empty;

  logic [PAYLOAD_WIDTH-1:0] cell_pay  [DEPTH];
  logic signed [7:0]        cell_prio [DEPTH];
  logic [7:0]               cell_pat  [DEPTH];
  logic [DEPTH-1:0]         cell_keep;
  logic [DEPTH-1:0]         cell_dead;
  logic [DEPTH-1:0]         cell_occ;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                     l_keep;
      logic                     l_dead;
      logic [PAYLOAD_WIDTH-1:0] l_pay, r_pay;
      logic signed [7:0]        l_prio, r_prio;
      logic [7:0]               l_pat, r_pat;

      assign cell_occ[gi] = (CW'(gi) < count_q);

      if (gi == 0) begin : g_first
        assign l_keep = 1'b1;
        assign l_dead = 1'b0;
        assign l_pay  = in_payload_i;
        assign l_prio = ctrl.prio;
        assign l_pat  = ctrl.pat;
      end else begin : g_inner
        assign l_keep = cell_keep[gi-1];
        assign l_dead = cell_dead[gi-1];
        assign l_pay  = cell_pay[gi-1];
        assign l_prio = cell_prio[gi-1];
        assign l_pat  = cell_pat[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign r_pay  = cell_pay[gi];
        assign r_prio = cell_prio[gi];
        assign r_pat  = cell_pat[gi];
      end else begin : g_body
        assign r_pay  = cell_pay[gi+1];
        assign r_prio = cell_prio[gi+1];
        assign r_pat  = cell_pat[gi+1];
      end

      spqa_cell #(
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
      ) u_cell (
        .clk_i          (clk_i),
        .ctrl_i         (ctrl),
        .ins_payload_i  (in_payload_i),
        .occ_i          (cell_occ[gi]),
        .left_keep_i    (l_keep),
        .dead_left_i    (l_dead),
        .left_payload_i (l_pay),
        .left_prio_i    (l_prio),
        .left_pat_i     (l_pat),
        .right_payload_i(r_pay),
        .right_prio_i   (r_prio),
        .right_pat_i    (r_pat),
        .keep_o         (cell_keep[gi]),
        .dead_o         (cell_dead[gi]),
        .payload_o      (cell_pay[gi]),
        .prio_o         (cell_prio[gi]),
        .pat_o          (cell_pat[gi])
      );
    end
  endgenerate

  assign out_free   = !res_valid_q || res_ready_i;
  assign op_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = op_valid_i && op_ready_o;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.cmd  = CMD_HOLD;
    ctrl.prio = in_priority_i;
    ctrl.pat  = in_patience_i;
    count_d   = count_q;
    state_d   = state_q;
    load      = 1'b0;
    status_d  = STATUS_OK;
    rvld_d    = 1'b0;
    if (state_q == S_PURGE) begin
      if (cell_dead[DEPTH-1]) begin
        ctrl.cmd = CMD_PURGE;
        count_d  = count_q - CW'(1);
      end else if (out_free) begin
        load    = 1'b1;
        state_d = S_IDLE;
      end
    end else if (accept) begin
      case (operation_i)
        OP_INSERT, OP_FRONT: begin
          load = 1'b1;
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            ctrl.cmd = CMD_INSERT;
            count_d  = count_q + CW'(1);
            if (operation_i == OP_FRONT) begin
              if (empty) begin
                ctrl.prio = base_q;
              end else if (cell_prio[0] == PRIO_MIN) begin
                ctrl.prio = PRIO_MIN;
              end else begin
                ctrl.prio = cell_prio[0] - 8'sd1;
              end
            end
          end
        end
        OP_REMOVE: begin
          load = 1'b1;
          if (empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            ctrl.cmd = CMD_SHIFT;
            rvld_d   = 1'b1;
            count_d  = count_q - CW'(1);
          end
        end
        OP_TICK: begin
          load     = 1'b1;
          ctrl.cmd = CMD_TICK;
        end
        OP_PURGE: begin
          state_d = S_PURGE;
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      base_q      <= FRONT_BASE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      rvld_q   <= rvld_d;
      rpay_q   <= rvld_d ? cell_pay[0] : '0;
      rprio_q  <= rvld_d ? cell_prio[0] : 8'sd0;
      rpat_q   <= rvld_d ? cell_pat[0] : 8'd0;
      occ_q    <= 4'(count_d);
    end
  end

  assign res_valid_o    = res_valid_q;
  assign status_o       = status_q;
  assign out_valid_o    = rvld_q;
  assign out_payload_o  = rpay_q;
  assign out_priority_o = rprio_q;
  assign out_patience_o = rpat_q;
  assign occupancy_o    = occ_q;

  `SPQA_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "Entry count exceeds the queue depth.")
  `SPQA_ASSERT_IMPL(a_purge_blocks, state_q == S_PURGE, !op_ready_o,
                    "Input ready during a purge.")
  `SPQA_ASSERT_IMPL(a_head_status, res_valid_o && out_valid_o, status_o == STATUS_OK,
                    "Removed head with a reject status.")
  `SPQA_ASSERT_NEXT(a_remove_count, accept && (operation_i == OP_REMOVE) && !empty,
                    count_q == $past(count_q) - CW'(1),
                    "Remove did not lower the count by one.")

endmodule
